@@ src/aac_pkg.sv @@
// shared types and constants for the activity level classifier
// no dependencies; imported by every module of the block
`default_nettype none

package aac_pkg;

  // item function codes
  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_UPRIGHT = 2'd1;
  localparam logic [1:0] FUNC_DAILY   = 2'd2;

  // activity level codes
  localparam logic [2:0] LVL_UNKNOWN   = 3'd0;
  localparam logic [2:0] LVL_SEDENTARY = 3'd1;
  localparam logic [2:0] LVL_LIGHT     = 3'd2;
  localparam logic [2:0] LVL_MODERATE  = 3'd3;
  localparam logic [2:0] LVL_VIGOROUS  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd0;
  localparam logic [2:0] REG_ALERT_RUN_SECS = 3'd1;
  localparam logic [2:0] REG_GRAVITY_OFFSET = 3'd2;
  localparam logic [2:0] REG_LIGHT_THR      = 3'd3;
  localparam logic [2:0] REG_MODERATE_THR   = 3'd4;
  localparam logic [2:0] REG_VIGOROUS_THR   = 3'd5;

  // configuration reset values
  localparam logic [7:0]  RST_WINDOW_LENGTH  = 8'd60;
  localparam logic [31:0] RST_ALERT_RUN_SECS = 32'd1800;
  localparam logic [15:0] RST_GRAVITY_OFFSET = 16'd1024;
  localparam logic [15:0] RST_LIGHT_THR      = 16'd50;
  localparam logic [15:0] RST_MODERATE_THR   = 16'd150;
  localparam logic [15:0] RST_VIGOROUS_THR   = 16'd400;

  // alpha-max beta-min coefficients, scaled by 2^MAG_SHIFT
  localparam int unsigned MAG_ALPHA = 983;
  localparam int unsigned MAG_BETA  = 408;
  localparam int unsigned MAG_SHIFT = 10;

  // seconds to minutes: secs / 60 = (secs * MIN_RECIP) >> MIN_SHIFT, exact for 32-bit secs
  localparam logic [31:0] MIN_RECIP = 32'h8888_8889;
  localparam int unsigned MIN_SHIFT = 37;

  // window divider step count, minute totals handled one per cycle
  localparam int unsigned WIN_STEPS = 24;
  localparam int unsigned MIN_LANES = 3;

  // minute total lanes
  localparam logic [1:0] LANE_ACT = 2'd0;
  localparam logic [1:0] LANE_SED = 2'd1;
  localparam logic [1:0] LANE_UP  = 2'd2;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  level;
    logic        window_done;
    logic [15:0] active_minutes;
    logic [15:0] sedentary_minutes;
    logic [15:0] upright_minutes;
    logic        sedentary_alert;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] dyn;
  } job_t;

  typedef struct packed {
    logic [7:0]  window_length;
    logic [31:0] alert_run_secs;
    logic [15:0] gravity_offset;
    logic [15:0] light_thr;
    logic [15:0] moderate_thr;
    logic [15:0] vigorous_thr;
  } cfg_t;

  // queue write port: push from the front and the queue full flag
  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

endpackage

`default_nettype wire

@@ src/aac_front.sv @@
// front end: accepts items, forms the dynamic magnitude of samples
// depends on aac_pkg; feeds aac_fifo
`default_nettype none

module aac_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  aac_pkg::in_item_t in_data,
  input  logic [15:0]      gravity_offset,
  input  logic             q_full,
  output logic             q_push,
  output aac_pkg::job_t    q_data
);
  import aac_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SORT = 4'b0010,
    F_MAG  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;
  in_item_t item_r;
  logic [15:0] max_r, mid_r;
  logic [15:0] max_nxt, mid_nxt;
  logic [15:0] ax, ay, az;
  logic [26:0] mag_acc;
  logic [16:0] mag;
  logic [15:0] dyn_nxt;
  job_t job_r;

  // absolute value of the low sample bits as two's complement
  function automatic logic [15:0] abs_axis(logic [15:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] n;
    v = raw[SAMPLE_BITS-1:0];
    n = ~v + 1'b1;
    return 16'(v[SAMPLE_BITS-1] ? n : v);
  endfunction

  // abs and max/mid selection
  always_comb begin
    ax = abs_axis(item_r.accel_x);
    ay = abs_axis(item_r.accel_y);
    az = abs_axis(item_r.accel_z);
    if (ax >= ay && ax >= az) begin
      max_nxt = ax;
      mid_nxt = (ay >= az) ? ay : az;
    end else if (ay >= az) begin
      max_nxt = ay;
      mid_nxt = (ax >= az) ? ax : az;
    end else begin
      max_nxt = az;
      mid_nxt = (ax >= ay) ? ax : ay;
    end
  end

  // magnitude minus gravity, clamped at zero
  always_comb begin
    mag_acc = 27'(max_r) * 27'(MAG_ALPHA) + 27'(mid_r) * 27'(MAG_BETA);
    mag     = mag_acc[26:MAG_SHIFT];
    if (mag > {1'b0, gravity_offset}) begin
      dyn_nxt = 16'(mag - {1'b0, gravity_offset});
    end else begin
      dyn_nxt = '0;
    end
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_SORT;
      F_SORT: state_nxt = F_MAG;
      F_MAG:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) item_r <= in_data;
    if (state_r == F_SORT) begin
      max_r <= max_nxt;
      mid_r <= mid_nxt;
    end
    if (state_r == F_MAG) begin
      job_r.func <= item_r.func;
      job_r.dyn  <= dyn_nxt;
    end
  end

  assign in_stall = (state_r != F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = job_r;

endmodule

`default_nettype wire

@@ src/aac_fifo.sv @@
// short queue of classified items between front and back
// depends on aac_pkg
`default_nettype none

module aac_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  aac_pkg::qwr_t wr,
  input  aac_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output aac_pkg::job_t rd_data
);
  import aac_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t mem_r [QDEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;
  logic do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign full      = (cnt_r == CW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr.push) mem_r[wptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr.push) begin
        wptr_r <= (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (wr.push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!wr.push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ src/aac_back.sv @@
// back end: window accumulation, serial division, daily counters, result register
// depends on aac_pkg; fed by aac_fifo
`default_nettype none

module aac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  aac_pkg::cfg_t      cfg,
  input  logic               job_valid,
  input  aac_pkg::job_t      job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output aac_pkg::out_item_t out_data
);
  import aac_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE   = 7'b0000001,
    B_ACC    = 7'b0000010,
    B_WDIV   = 7'b0000100,
    B_CLASS  = 7'b0001000,
    B_MSTART = 7'b0010000,
    B_MDIV   = 7'b0100000,
    B_OUT    = 7'b1000000
  } bstate_t;

  bstate_t state_r;
  job_t job_r;
  logic [23:0] sum_r;
  logic [7:0]  fill_r;
  logic [2:0]  level_r;
  logic        done_r;
  logic [31:0] sed_r, act_r, up_r, run_r;
  logic [7:0]  rem_r;
  logic [31:0] quo_r;
  logic [15:0] min_r [MIN_LANES];
  logic [4:0]  step_r;
  logic out_valid_r;
  out_item_t out_r;

  logic [7:0]  len;
  logic [23:0] sum_nxt;
  logic [7:0]  fill_nxt;
  logic [23:0] avg;
  logic [39:0] step_res;
  logic [31:0] secs;
  logic [63:0] recip_prod;
  logic        out_free;

  // one restoring division step: shift in the next dividend bit
  function automatic logic [39:0] div_step(logic [7:0] rem, logic [31:0] quo,
                                           logic [7:0] d);
    logic [8:0] sh;
    logic [8:0] diff;
    logic [39:0] res;
    sh   = {rem, quo[31]};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) res = {diff[7:0], quo[30:0], 1'b1};
    else res = {sh[7:0], quo[30:0], 1'b0};
    return res;
  endfunction

  // window bookkeeping
  always_comb begin
    len      = (cfg.window_length == '0) ? 8'd1 : cfg.window_length;
    sum_nxt  = sum_r + 24'(job_r.dyn);
    fill_nxt = fill_r + 1'b1;
    avg      = quo_r[23:0];
    step_res = div_step(rem_r, quo_r, len);
    // one minute total per cycle by reciprocal multiply
    case (step_r[1:0])
      LANE_ACT: secs = act_r;
      LANE_SED: secs = sed_r;
      default:  secs = up_r;
    endcase
    recip_prod = 64'(secs) * 64'(MIN_RECIP);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign job_pop  = (state_r == B_IDLE) && job_valid;

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      fill_r      <= '0;
      level_r     <= LVL_UNKNOWN;
      sed_r       <= '0;
      act_r       <= '0;
      up_r        <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: loaded when free, emptied by a transfer
      if (state_r == B_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (job_valid) state_r <= (job.func == FUNC_SAMPLE) ? B_ACC : B_MSTART;
          if (job_valid && job.func == FUNC_UPRIGHT) up_r <= up_r + 1'b1;
          if (job_valid && job.func == FUNC_DAILY) begin
            sed_r   <= '0;
            act_r   <= '0;
            up_r    <= '0;
            run_r   <= '0;
            level_r <= LVL_UNKNOWN;
          end
        end
        B_ACC: begin
          if (fill_nxt >= len) begin
            sum_r   <= '0;
            fill_r  <= '0;
            state_r <= B_WDIV;
          end else begin
            sum_r   <= sum_nxt;
            fill_r  <= fill_nxt;
            state_r <= B_MSTART;
          end
        end
        B_WDIV: begin
          if (step_r == 5'(WIN_STEPS - 1)) state_r <= B_CLASS;
        end
        B_CLASS: begin
          if (avg < 24'(cfg.light_thr)) begin
            level_r <= LVL_SEDENTARY;
            sed_r   <= sed_r + 32'(len);
            run_r   <= run_r + 32'(len);
          end else begin
            run_r <= '0;
            if (avg < 24'(cfg.moderate_thr)) begin
              level_r <= LVL_LIGHT;
            end else begin
              level_r <= (avg < 24'(cfg.vigorous_thr)) ? LVL_MODERATE : LVL_VIGOROUS;
              act_r   <= act_r + 32'(len);
            end
          end
          state_r <= B_MSTART;
        end
        B_MSTART: state_r <= B_MDIV;
        B_MDIV: begin
          if (step_r == 5'(MIN_LANES - 1)) state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // divider, minute totals and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_r  <= job;
          done_r <= 1'b0;
        end
      end
      B_ACC: begin
        rem_r  <= '0;
        quo_r  <= {sum_nxt, 8'h00};
        step_r <= '0;
        done_r <= (fill_nxt >= len);
      end
      B_MSTART: begin
        step_r <= '0;
      end
      B_WDIV: begin
        rem_r  <= step_res[39:32];
        quo_r  <= step_res[31:0];
        step_r <= step_r + 1'b1;
      end
      B_MDIV: begin
        min_r[step_r[1:0]] <= recip_prod[MIN_SHIFT +: 16];
        step_r <= step_r + 1'b1;
      end
      B_OUT: begin
        if (out_free) begin
          out_r.level             <= level_r;
          out_r.window_done       <= done_r;
          out_r.active_minutes    <= min_r[LANE_ACT];
          out_r.sedentary_minutes <= min_r[LANE_SED];
          out_r.upright_minutes   <= min_r[LANE_UP];
          out_r.sedentary_alert   <= (run_r >= cfg.alert_run_secs);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ src/accel_activity_classifier_top.sv @@
// top level of the activity level classifier: config registers and wiring
// depends on aac_pkg, aac_front, aac_fifo, aac_back
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  in_      | in        | in_valid/in_stall  | in_data   (func, three axes)
//  out_     | out       | out_valid/out_stall| out_data  (level, minutes, alert)
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// front: takes no new item until the last one is pushed; the push waits while the queue is full
// back: a tick, daily reset or unused code skips to the minute totals; a sample that
//   closes a window adds a 24-step serial divide for the average; one minute total per cycle
// rst_n low (synchronous) restores config defaults and clears all counters
// out_stall holds the result register; the back finishes the next item behind it, then
//   the queue fills and the front raises in_stall; cfg_ready is always high
`default_nettype none

module accel_activity_classifier_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aac_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aac_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import aac_pkg::*;

  cfg_t cfg_r;
  qwr_t qwr;
  job_t front_job, back_job;
  logic q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length  <= RST_WINDOW_LENGTH;
      cfg_r.alert_run_secs <= RST_ALERT_RUN_SECS;
      cfg_r.gravity_offset <= RST_GRAVITY_OFFSET;
      cfg_r.light_thr      <= RST_LIGHT_THR;
      cfg_r.moderate_thr   <= RST_MODERATE_THR;
      cfg_r.vigorous_thr   <= RST_VIGOROUS_THR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:  cfg_r.window_length  <= cfg_wdata[7:0];
        REG_ALERT_RUN_SECS: cfg_r.alert_run_secs <= cfg_wdata;
        REG_GRAVITY_OFFSET: cfg_r.gravity_offset <= cfg_wdata[15:0];
        REG_LIGHT_THR:      cfg_r.light_thr      <= cfg_wdata[15:0];
        REG_MODERATE_THR:   cfg_r.moderate_thr   <= cfg_wdata[15:0];
        REG_VIGOROUS_THR:   cfg_r.vigorous_thr   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign qwr.push = q_push;
  assign qwr.full = q_full;

  aac_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .gravity_offset (cfg_r.gravity_offset),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (front_job)
  );

  aac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (qwr),
    .wr_data   (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_data   (back_job)
  );

  aac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job       (back_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ src/aac_checker.sv @@
// port-level checks for the activity level classifier, bound to the top level
// depends on aac_pkg and accel_activity_classifier_top
`default_nettype none

module aac_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input aac_pkg::out_item_t out_data
);
  import aac_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // a closed window always carries a classified level
  a_done_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.window_done |-> out_data.level != LVL_UNKNOWN)
    else $error("window done with unknown level");

  // front is busy in the cycle after a transfer in
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front accepted two items back to back");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind accel_activity_classifier_top aac_checker u_aac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
